FILE: hdl/tilp_pkg.sv
// shared types, constants and reset helpers for the three-axis iir low-pass filter
`default_nettype none

package tilp_pkg;

    localparam int COEF_BITS       = 24;
    localparam int HIST_FRAC       = 8;
    localparam int NUM_AXES        = 3;
    localparam int NUM_COEFS       = 7;
    localparam int CFG_IDX_BITS    = 3;
    localparam int RESET_FRAC_BITS = 21;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t REG_B_OUTER = 3'd0;
    localparam cfg_idx_t REG_B_INNER = 3'd1;
    localparam cfg_idx_t REG_B_MID   = 3'd2;
    localparam cfg_idx_t REG_A_ONE   = 3'd3;
    localparam cfg_idx_t REG_A_TWO   = 3'd4;
    localparam cfg_idx_t REG_A_THREE = 3'd5;
    localparam cfg_idx_t REG_A_FOUR  = 3'd6;

    // coefficient reset values in q2.21
    localparam longint COEF_RESET_Q21 [NUM_COEFS] = '{
        21411, 85643, 128465, -4128092, 3640364, -1519325, 252475
    };

    typedef struct packed {
        coef_t b_outer;
        coef_t b_inner;
        coef_t b_mid;
        coef_t a_one;
        coef_t a_two;
        coef_t a_three;
        coef_t a_four;
    } coefs_t;

    // lane sequencer steps
    typedef enum logic [1:0] {
        STEP_FWD,
        STEP_FB,
        STEP_TAIL,
        STEP_SUM
    } step_t;

    typedef struct packed {
        logic  start;
        step_t step;
        logic  fin;
    } lane_ctl_t;

    // reset coefficient rescaled to the chosen fraction width, rounded half up
    function automatic coef_t coef_reset(input int k, input int frac_bits);
        longint v;
        longint lim;
        int     e;
        v   = COEF_RESET_Q21[k];
        lim = (longint'(1) <<< (COEF_BITS - 1)) - 1;
        if (frac_bits >= RESET_FRAC_BITS) begin
            v = v <<< (frac_bits - RESET_FRAC_BITS);
        end
        else begin
            e = RESET_FRAC_BITS - frac_bits;
            v = (v + (longint'(1) <<< (e - 1))) >>> e;
        end
        if (v > lim) begin
            v = lim;
        end
        else if (v < -lim - 1) begin
            v = -lim - 1;
        end
        return coef_t'(v);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tilp_ifs.sv
// valid/ready channel interfaces for the sample and filtered streams
`default_nettype none

interface tilp_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_x;
    logic signed [W-1:0] sample_y;
    logic signed [W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface tilp_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered_x;
    logic signed [W-1:0] filtered_y;
    logic signed [W-1:0] filtered_z;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/tilp_lane.sv
// one axis filter lane: history, three shared multipliers and the accumulator
`default_nettype none

module tilp_lane #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  tilp_pkg::lane_ctl_t                           ctl,
    input  tilp_pkg::coefs_t                              coefs,
    input  logic signed [SAMPLE_BITS-1:0]                 sample,
    output logic signed [SAMPLE_BITS+tilp_pkg::HIST_FRAC-1:0] y
);
    import tilp_pkg::*;

    localparam int YW  = SAMPLE_BITS + HIST_FRAC;
    localparam int PW  = COEF_BITS + YW;
    localparam int AW  = PW + 4;
    localparam int TAPS = 4;
    localparam int MULS = 3;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] xh_reg [TAPS];
    logic signed [YW-1:0]          yh_reg [TAPS];
    logic signed [PW-1:0]          prod_reg [MULS];
    logic signed [PW-1:0]          prod_next [MULS];
    logic                          fwd_reg;
    logic signed [AW-1:0]          acc_reg;

    logic signed [SAMPLE_BITS:0]   pair_outer;
    logic signed [SAMPLE_BITS:0]   pair_inner;
    coef_t                         cm [MULS];
    logic signed [YW-1:0]          dm [MULS];
    logic signed [AW-1:0]          term [MULS];
    logic signed [AW-1:0]          sum;
    logic signed [AW-1:0]          q;
    logic signed [YW-1:0]          y_sat;

    // symmetric numerator pairs
    assign pair_outer = (SAMPLE_BITS+1)'(x_reg) + (SAMPLE_BITS+1)'(xh_reg[3]);
    assign pair_inner = (SAMPLE_BITS+1)'(xh_reg[0]) + (SAMPLE_BITS+1)'(xh_reg[2]);

    // multiplier operand schedule
    always_comb
    begin
        unique case (ctl.step)
            STEP_FWD:
            begin
                cm[0] = coefs.b_outer; dm[0] = YW'(pair_outer);
                cm[1] = coefs.b_inner; dm[1] = YW'(pair_inner);
                cm[2] = coefs.b_mid;   dm[2] = YW'(xh_reg[1]);
            end
            STEP_FB:
            begin
                cm[0] = coefs.a_one;   dm[0] = yh_reg[0];
                cm[1] = coefs.a_two;   dm[1] = yh_reg[1];
                cm[2] = coefs.a_three; dm[2] = yh_reg[2];
            end
            STEP_TAIL:
            begin
                cm[0] = coefs.a_four;  dm[0] = yh_reg[3];
                cm[1] = '0;            dm[1] = '0;
                cm[2] = '0;            dm[2] = '0;
            end
            STEP_SUM:
            begin
                cm[0] = '0; dm[0] = '0;
                cm[1] = '0; dm[1] = '0;
                cm[2] = '0; dm[2] = '0;
            end
        endcase
        for (int i = 0; i < MULS; i++)
        begin
            prod_next[i] = cm[i] * dm[i];
        end
    end

    // product registers, loaded on the three multiply steps
    always_ff @(posedge clk)
    begin
        if (ctl.step != STEP_SUM)
        begin
            prod_reg <= prod_next;
            fwd_reg  <= (ctl.step == STEP_FWD);
        end
    end

    // forward terms gain the history fraction, feedback terms are subtracted
    always_comb
    begin
        for (int i = 0; i < MULS; i++)
        begin
            term[i] = fwd_reg ? (AW'(prod_reg[i]) <<< HIST_FRAC) : -AW'(prod_reg[i]);
        end
        sum = acc_reg + term[0] + term[1] + term[2];
    end

    // accumulator, preloaded with the rounding half
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= ROUND_HALF;
            x_reg   <= sample;
        end
        else if (ctl.step == STEP_FB || ctl.step == STEP_TAIL)
        begin
            acc_reg <= sum;
        end
    end

    // scale down and saturate to the history range
    always_comb
    begin
        q = sum >>> COEF_FRAC_BITS;
        if (q[AW-1:YW-1] == '0 || q[AW-1:YW-1] == '1)
        begin
            y_sat = q[YW-1:0];
        end
        else if (q[AW-1])
        begin
            y_sat = {1'b1, {(YW-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(YW-1){1'b1}}};
        end
    end

    assign y = y_sat;

    // input and output history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                xh_reg[t] <= '0;
                yh_reg[t] <= '0;
            end
        end
        else if (ctl.fin)
        begin
            for (int t = TAPS - 1; t > 0; t--)
            begin
                xh_reg[t] <= xh_reg[t-1];
                yh_reg[t] <= yh_reg[t-1];
            end
            xh_reg[0] <= x_reg;
            yh_reg[0] <= y_sat;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tilp_merge.sv
// merges the three lane results into the output register with final rounding
`default_nettype none

module tilp_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              fin,
    input  logic signed [SAMPLE_BITS+tilp_pkg::HIST_FRAC-1:0] lane_y_x,
    input  logic signed [SAMPLE_BITS+tilp_pkg::HIST_FRAC-1:0] lane_y_y,
    input  logic signed [SAMPLE_BITS+tilp_pkg::HIST_FRAC-1:0] lane_y_z,
    output logic                                              free,
    tilp_out_if.source                                        filtered
);
    import tilp_pkg::*;

    localparam int YW = SAMPLE_BITS + HIST_FRAC;
    localparam logic signed [YW:0] HALF = (YW+1)'(1) <<< (HIST_FRAC - 1);

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [YW-1:0] yx_reg;
    logic signed [YW-1:0] yy_reg;
    logic signed [YW-1:0] yz_reg;

    // round half up to an integer sample and saturate
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [YW-1:0] v);
        logic signed [YW:0]          r;
        logic signed [SAMPLE_BITS:0] t;
        r = (YW+1)'(v) + HALF;
        t = r[YW:HIST_FRAC];
        if (t[SAMPLE_BITS] != t[SAMPLE_BITS-1])
        begin
            return {t[SAMPLE_BITS], {(SAMPLE_BITS-1){~t[SAMPLE_BITS]}}};
        end
        return t[SAMPLE_BITS-1:0];
    endfunction

    assign free = !valid_reg || filtered.ready;

    // output valid
    always_comb
    begin
        priority if (fin)
        begin
            valid_next = 1'b1;
        end
        else if (filtered.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            yx_reg <= lane_y_x;
            yy_reg <= lane_y_y;
            yz_reg <= lane_y_z;
        end
    end

    assign filtered.valid      = valid_reg;
    assign filtered.filtered_x = round_sat(yx_reg);
    assign filtered.filtered_y = round_sat(yy_reg);
    assign filtered.filtered_z = round_sat(yz_reg);

endmodule

`default_nettype wire

FILE: hdl/three_axis_iir_lowpass_top.sv
// top level of the three-axis fourth-order iir low-pass filter
// sequence: a request runs the forward, feedback, tail and summing steps, the summing
//   step waiting while the output register is full; the next request is taken as it ends,
//   as the feedback recurrence reuses each lane's three multipliers over three steps
// reset: histories clear to zero and coefficients return to their defaults;
//   no clearing pass, the block takes requests right after reset
`default_nettype none

module three_axis_iir_lowpass_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    tilp_in_if.sink           samples,
    tilp_out_if.source        filtered,
    input  logic              cfg_we,
    input  tilp_pkg::cfg_idx_t cfg_index,
    input  tilp_pkg::coef_t   cfg_data
);
    import tilp_pkg::*;

    localparam int YW = SAMPLE_BITS + HIST_FRAC;

    localparam coefs_t COEFS_RESET = '{
        b_outer: coef_reset(0, COEF_FRAC_BITS),
        b_inner: coef_reset(1, COEF_FRAC_BITS),
        b_mid:   coef_reset(2, COEF_FRAC_BITS),
        a_one:   coef_reset(3, COEF_FRAC_BITS),
        a_two:   coef_reset(4, COEF_FRAC_BITS),
        a_three: coef_reset(5, COEF_FRAC_BITS),
        a_four:  coef_reset(6, COEF_FRAC_BITS)
    };

    coefs_t    coefs_reg;
    logic      busy_reg;
    logic      busy_next;
    step_t     step_reg;
    step_t     step_next;
    logic      start;
    logic      fin;
    logic      out_free;
    lane_ctl_t ctl;

    logic signed [SAMPLE_BITS-1:0] lane_in [NUM_AXES];
    logic signed [YW-1:0]          lane_y  [NUM_AXES];

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= COEFS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B_OUTER: coefs_reg.b_outer <= cfg_data;
                REG_B_INNER: coefs_reg.b_inner <= cfg_data;
                REG_B_MID:   coefs_reg.b_mid   <= cfg_data;
                REG_A_ONE:   coefs_reg.a_one   <= cfg_data;
                REG_A_TWO:   coefs_reg.a_two   <= cfg_data;
                REG_A_THREE: coefs_reg.a_three <= cfg_data;
                REG_A_FOUR:  coefs_reg.a_four  <= cfg_data;
                default:     coefs_reg         <= coefs_reg;
            endcase
        end
    end

    // handshake and lane sequencing
    assign fin           = busy_reg && (step_reg == STEP_SUM) && out_free;
    assign samples.ready = !busy_reg || fin;
    assign start         = samples.valid && samples.ready;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_FWD;
        end
        else
        begin
            if (fin)
            begin
                busy_next = 1'b0;
            end
            unique case (step_reg)
                STEP_FWD:  step_next = STEP_FB;
                STEP_FB:   step_next = STEP_TAIL;
                STEP_TAIL: step_next = STEP_SUM;
                STEP_SUM:  step_next = STEP_SUM;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_SUM;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctl = '{start: start, step: step_reg, fin: fin};

    // one lane per axis
    assign lane_in[0] = samples.sample_x;
    assign lane_in[1] = samples.sample_y;
    assign lane_in[2] = samples.sample_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        tilp_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .coefs  (coefs_reg),
            .sample (lane_in[a]),
            .y      (lane_y[a])
        );
    end

    // output register
    tilp_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .fin      (fin),
        .lane_y_x (lane_y[0]),
        .lane_y_y (lane_y[1]),
        .lane_y_z (lane_y[2]),
        .free     (out_free),
        .filtered (filtered)
    );

endmodule

`default_nettype wire

FILE: hdl/tilp_check.sv
// port-level checks for the three-axis iir low-pass filter, bound to the top
`default_nettype none

module tilp_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    logic in_req;

    assign in_req = in_valid && in_ready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // after a request, the lanes refuse new requests through the forward, feedback and tail steps
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("request taken while lanes busy");

    // a fresh result must be preceded by its own request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_req, 5))
        else $error("result without matching request");

endmodule

bind three_axis_iir_lowpass_top tilp_check u_tilp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (filtered.valid),
    .out_ready (filtered.ready)
);

`default_nettype wire
